// ----- rtl/kvmc_pkg.sv -----
// Shared types and constants for the knob volume and mode controller.
`timescale 1ns / 1ps

package kvmc_pkg;

    localparam int TICK_CFG_W = 13;
    localparam int LEVEL_W    = 7;
    localparam int OFFSET_W   = 5;
    localparam int LIMIT_W    = 4;
    localparam int PENDING_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_FLOOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ATTEN_LIMIT  = 3'd5;

    // Reset values
    localparam logic [TICK_CFG_W-1:0] LONG_PRESS_RST   = 13'd3000;
    localparam logic [TICK_CFG_W-1:0] SHORT_PRESS_RST  = 13'd500;
    localparam logic [TICK_CFG_W-1:0] IDLE_TIMEOUT_RST = 13'd4000;
    localparam logic [LEVEL_W-1:0]    VOLUME_FLOOR_RST = 7'd85;
    localparam logic [LIMIT_W-1:0]    OFFSET_LIMIT_RST = 4'd15;
    localparam logic [LEVEL_W-1:0]    ATTEN_LIMIT_RST  = 7'd90;
    localparam logic [LEVEL_W-1:0]    MAIN_LEVEL_RST   = 7'd60;
    localparam logic [OFFSET_W-1:0]   SUB_OFFSET_RST   = 5'd2;

    typedef struct packed {
        logic [TICK_CFG_W-1:0] long_press;
        logic [TICK_CFG_W-1:0] short_press;
        logic [TICK_CFG_W-1:0] idle_timeout;
        logic [LEVEL_W-1:0]    volume_floor;
        logic [LIMIT_W-1:0]    offset_limit;
        logic [LEVEL_W-1:0]    atten_limit;
    } cfg_t;

    typedef struct packed {
        logic power_toggle;
        logic mode_toggle;
    } press_evt_t;

endpackage

// ----- rtl/knob_volume_mode_controller.sv -----
// Top level of the knob volume and mode controller.
`timescale 1ns / 1ps

// One input item per tick carries the encoder A/B levels and the button level;
// each item yields exactly one result item with power, mode, main attenuation,
// sub offset, sub attenuation and a flag that the levels changed. The block
// takes one item per clock cycle while the output is not stalled: an item waits
// in the input register while its full update is computed, and its result is
// loaded into the output register when the item advances. A stalled output
// holds both stages; input ready stays high as long as the input register can
// move on. Configuration writes take effect at the next clock edge.

module knob_volume_mode_controller
    import kvmc_pkg::*;
#(
    parameter int TICK_COUNT_BITS = 13
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  enc_a,
    input  logic                  enc_b,
    input  logic                  button_low,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  power_on,
    output logic                  sub_mode,
    output logic [LEVEL_W-1:0]    main_attenuation,
    output logic signed [OFFSET_W-1:0] sub_offset_value,
    output logic [LEVEL_W-1:0]    sub_attenuation,
    output logic                  channels_written,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CMP_W = (TICK_COUNT_BITS > TICK_CFG_W) ? TICK_COUNT_BITS : TICK_CFG_W;
    localparam int SUM_W = 10;

    cfg_t cfg_reg;

    // input stage
    logic s1_valid_reg;
    logic s1_a_reg, s1_b_reg, s1_btn_reg;
    logic advance;

    // block state
    logic [PENDING_W-1:0]       pending_reg;
    logic                       last_a_reg;
    logic [TICK_COUNT_BITS-1:0] idle_reg, idle_next;
    logic                       power_reg, power_next;
    logic                       mode_reg, mode_next;
    logic [LEVEL_W-1:0]         main_reg, main_next;
    logic [OFFSET_W-1:0]        offset_reg, offset_next;
    logic [PENDING_W-1:0]       pending_next;
    logic                       last_a_next;

    // result stage
    logic                  out_valid_reg;
    logic                  o_power_reg, o_mode_reg, o_written_reg;
    logic [LEVEL_W-1:0]    o_main_reg, o_sub_att_reg;
    logic [OFFSET_W-1:0]   o_offset_reg;
    logic [LEVEL_W-1:0]    sub_att_next;
    logic                  written_next;

    press_evt_t evt;

    logic [PENDING_W-1:0]       pending_acc;
    logic signed [PENDING_W-1:0] delta;
    logic signed [SUM_W-1:0]    main_sum, sub_sum, att_sum, lim_pos, lim_neg;
    logic [TICK_COUNT_BITS-1:0] idle_inc;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press   <= LONG_PRESS_RST;
            cfg_reg.short_press  <= SHORT_PRESS_RST;
            cfg_reg.idle_timeout <= IDLE_TIMEOUT_RST;
            cfg_reg.volume_floor <= VOLUME_FLOOR_RST;
            cfg_reg.offset_limit <= OFFSET_LIMIT_RST;
            cfg_reg.atten_limit  <= ATTEN_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LONG_PRESS:   cfg_reg.long_press   <= cfg_data;
                REG_SHORT_PRESS:  cfg_reg.short_press  <= cfg_data;
                REG_IDLE_TIMEOUT: cfg_reg.idle_timeout <= cfg_data;
                REG_VOLUME_FLOOR: cfg_reg.volume_floor <= cfg_data[LEVEL_W-1:0];
                REG_OFFSET_LIMIT: cfg_reg.offset_limit <= cfg_data[LIMIT_W-1:0];
                REG_ATTEN_LIMIT:  cfg_reg.atten_limit  <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_a_reg   <= enc_a;
            s1_b_reg   <= enc_b;
            s1_btn_reg <= button_low;
        end
    end

    kvmc_press #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_press (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .button      (s1_btn_reg),
        .long_press  (cfg_reg.long_press),
        .short_press (cfg_reg.short_press),
        .evt         (evt)
    );

    assign idle_inc = (idle_reg == {TICK_COUNT_BITS{1'b1}}) ? idle_reg
                                                              : idle_reg + TICK_COUNT_BITS'(1);
    assign lim_pos  = $signed({{(SUM_W-LIMIT_W){1'b0}}, cfg_reg.offset_limit});
    assign lim_neg  = -lim_pos;

    always_comb
    begin
        // encoder step: plus one when B differs from A
        pending_acc = pending_reg;
        last_a_next = last_a_reg;
        if (s1_a_reg != last_a_reg)
        begin
            pending_acc = (s1_b_reg != s1_a_reg) ? pending_reg + PENDING_W'(1)
                                                 : pending_reg - PENDING_W'(1);
            last_a_next = s1_a_reg;
        end

        idle_next    = evt.mode_toggle ? '0 : idle_inc;
        power_next   = power_reg ^ evt.power_toggle;
        mode_next    = mode_reg ^ evt.mode_toggle;
        written_next = evt.power_toggle && power_next;
        main_next    = main_reg;
        offset_next  = offset_reg;
        pending_next = pending_acc;

        delta    = $signed(pending_acc);
        main_sum = $signed({{(SUM_W-LEVEL_W){1'b0}}, main_reg})
                 + $signed({{(SUM_W-PENDING_W){delta[PENDING_W-1]}}, delta});
        sub_sum  = $signed({{(SUM_W-OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg})
                 + $signed({{(SUM_W-PENDING_W){delta[PENDING_W-1]}}, delta});

        // pending total is applied only while power is on
        if (power_next)
        begin
            pending_next = '0;
            if (delta != '0)
            begin
                idle_next    = '0;
                written_next = 1'b1;
                if (!mode_next)
                begin
                    if (main_sum < 0)
                        main_next = '0;
                    else if (main_sum > $signed({{(SUM_W-LEVEL_W){1'b0}}, cfg_reg.volume_floor}))
                        main_next = cfg_reg.volume_floor;
                    else
                        main_next = main_sum[LEVEL_W-1:0];
                end
                else
                begin
                    if (sub_sum < lim_neg)
                        offset_next = lim_neg[OFFSET_W-1:0];
                    else if (sub_sum > lim_pos)
                        offset_next = lim_pos[OFFSET_W-1:0];
                    else
                        offset_next = sub_sum[OFFSET_W-1:0];
                end
            end
        end

        if (mode_next && (CMP_W'(idle_next) > CMP_W'(cfg_reg.idle_timeout)))
            mode_next = 1'b0;

        att_sum = $signed({{(SUM_W-LEVEL_W){1'b0}}, main_next})
                + $signed({{(SUM_W-OFFSET_W){offset_next[OFFSET_W-1]}}, offset_next});
        if (att_sum < 0)
            sub_att_next = '0;
        else if (att_sum > $signed({{(SUM_W-LEVEL_W){1'b0}}, cfg_reg.atten_limit}))
            sub_att_next = cfg_reg.atten_limit;
        else
            sub_att_next = att_sum[LEVEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            last_a_reg  <= 1'b1;
            idle_reg    <= '0;
            power_reg   <= 1'b1;
            mode_reg    <= 1'b0;
            main_reg    <= MAIN_LEVEL_RST;
            offset_reg  <= SUB_OFFSET_RST;
        end
        else if (advance)
        begin
            pending_reg <= pending_next;
            last_a_reg  <= last_a_next;
            idle_reg    <= idle_next;
            power_reg   <= power_next;
            mode_reg    <= mode_next;
            main_reg    <= main_next;
            offset_reg  <= offset_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            o_power_reg   <= power_next;
            o_mode_reg    <= mode_next;
            o_main_reg    <= main_next;
            o_offset_reg  <= offset_next;
            o_sub_att_reg <= sub_att_next;
            o_written_reg <= written_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign power_on         = o_power_reg;
    assign sub_mode         = o_mode_reg;
    assign main_attenuation = o_main_reg;
    assign sub_offset_value = $signed(o_offset_reg);
    assign sub_attenuation  = o_sub_att_reg;
    assign channels_written = o_written_reg;

    // the sub offset never leaves +-15
    assert property (@(posedge clk) disable iff (!rst_n)
        ($signed(offset_reg) >= -5'sd15) && ($signed(offset_reg) <= 5'sd15))
        else $error("sub offset out of range");

    // levels are sent only with power on
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!o_written_reg || o_power_reg))
        else $error("channels written while power off");

    // a full input stage that cannot drain refuses new items
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while both stages are stalled");

    // a stalled result stays valid and the state does not move
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(main_reg)))
        else $error("state advanced under output stall");

endmodule

// ----- rtl/kvmc_press.sv -----
// Button press tracker: hold timing, long-press and short-release events.
`timescale 1ns / 1ps

module kvmc_press
    import kvmc_pkg::*;
#(
    parameter int TICK_COUNT_BITS = 13
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  button,
    input  logic [TICK_CFG_W-1:0] long_press,
    input  logic [TICK_CFG_W-1:0] short_press,
    output press_evt_t            evt
);

    localparam int CMP_W = (TICK_COUNT_BITS > TICK_CFG_W) ? TICK_COUNT_BITS : TICK_CFG_W;

    logic                       active_reg, active_next;
    logic                       held_reg, held_next;
    logic [TICK_COUNT_BITS-1:0] ticks_reg, ticks_next;
    logic [TICK_COUNT_BITS-1:0] ticks_inc;

    assign ticks_inc = (ticks_reg == {TICK_COUNT_BITS{1'b1}}) ? ticks_reg
                                                                : ticks_reg + TICK_COUNT_BITS'(1);

    always_comb
    begin
        active_next = active_reg;
        held_next   = held_reg;
        ticks_next  = ticks_reg;
        evt         = '0;
        if (button)
        begin
            if (!active_reg)
            begin
                active_next = 1'b1;
                held_next   = 1'b0;
                ticks_next  = '0;
            end
            else
            begin
                ticks_next = ticks_inc;
                if (!held_reg && (CMP_W'(ticks_inc) >= CMP_W'(long_press)))
                begin
                    held_next        = 1'b1;
                    evt.power_toggle = 1'b1;
                end
            end
        end
        else
        begin
            // release after a short press, not consumed by a long hold
            if (active_reg && !held_reg && (CMP_W'(ticks_reg) > CMP_W'(short_press)))
            begin
                evt.mode_toggle = 1'b1;
            end
            active_next = 1'b0;
            held_next   = 1'b0;
            ticks_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            held_reg   <= 1'b0;
            ticks_reg  <= '0;
        end
        else if (advance)
        begin
            active_reg <= active_next;
            held_reg   <= held_next;
            ticks_reg  <= ticks_next;
        end
    end

endmodule
